// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property check on a clock with a synchronous reset
`define HRRN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hrrn assertion failed");

// implication form built on the check above
`define HRRN_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   `HRRN_ASSERT(lbl, clk, rst, (ante) |-> (cons))

`endif

// File: design/hrrn_pkg.sv
package hrrn_pkg;

   localparam int MAX_WAITING = 16;
   localparam int IDX_W       = $clog2(MAX_WAITING);
   localparam int CNT_W       = $clog2(MAX_WAITING + 1);

   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_ARRIVAL = 1'b1;

   typedef struct packed {
      logic        valid;
      logic [7:0]  id;
      logic [31:0] arrival;
      logic [15:0] left;
   } slot_type;

endpackage

// File: design/hrrn_cell.sv
module hrrn_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  hrrn_pkg::slot_type shift_in,
   input  logic               load_en,
   input  hrrn_pkg::slot_type load_data,
   input  logic               clear_en,
   output hrrn_pkg::slot_type slot_out
);
   import hrrn_pkg::*;

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (shift_en) begin
         slot_ff <= shift_in;
      end else if (load_en) begin
         slot_ff <= load_data;
      end else if (clear_en) begin
         slot_ff.valid <= 1'b0;
      end
   end

   assign slot_out = slot_ff;

endmodule

// File: design/hrrn_process_scheduler.sv
// arrival: the result is registered in the cycle after the transfer in
// tick with no selection needed: the result is likewise registered in the cycle after the transfer in
// tick with selection: from ST_IDLE the state steps through ST_MUL then ST_CMP for every slot
//   as the ring of slot cells rotates past one shared cross-multiplying comparator; ST_DONE then registers the result
// one item at a time; synchronous active-high reset empties the table and stops the runner
module hrrn_process_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_proc_id,
   input  logic [15:0] req_burst_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_run_valid,
   output logic [7:0]  rsp_run_id_out,
   output logic [15:0] rsp_run_left_out,
   output logic        rsp_dropped,
   output logic [4:0]  rsp_waiting_count
);
   import hrrn_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_CMP, ST_DONE} state_type;

   state_type   state_ff;
   logic        rsp_valid_ff;
   logic        rsp_run_valid_ff;
   logic [7:0]  rsp_run_id_ff;
   logic [15:0] rsp_run_left_ff;
   logic        rsp_dropped_ff;
   logic [4:0]  rsp_wcnt_ff;
   logic        run_present_ff;
   logic [7:0]  run_id_ff;
   logic [15:0] run_left_ff;
   logic [31:0] now_ff;
   logic [CNT_W-1:0] wcnt_ff;
   logic [IDX_W-1:0] scan_ff;
   logic        have_best_ff;
   logic [31:0] best_wait_ff;
   logic [15:0] best_left_ff;
   logic [7:0]  best_id_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [47:0] prod_a_ff;
   logic [47:0] prod_b_ff;

   slot_type slots [MAX_WAITING];
   slot_type head;
   slot_type new_slot;
   logic [MAX_WAITING-1:0] load_en;
   logic [MAX_WAITING-1:0] clear_en;
   logic [MAX_WAITING-1:0] valid_vec;
   logic [IDX_W-1:0] free_idx;
   logic        table_full;
   logic        accept;
   logic        queue_it;
   logic        need_sel;
   logic        rsp_set;
   logic [31:0] head_wait;
   logic        beats;
   logic [15:0] best_dec;

   assign head      = slots[0];
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign head_wait = now_ff - head.arrival;
   assign need_sel  = !run_present_ff || (run_left_ff == 16'd0);
   assign queue_it  = accept && (req_type == REQ_ARRIVAL) && run_present_ff && !table_full;
   assign best_dec  = (best_left_ff == 16'd0) ? 16'd0 : best_left_ff - 16'd1;
   assign rsp_set   = ((state_ff == ST_IDLE) && accept &&
                       !((req_type == REQ_TICK) && need_sel && (wcnt_ff != '0))) ||
                      (state_ff == ST_DONE);

   assign new_slot.valid   = 1'b1;
   assign new_slot.id      = req_proc_id;
   assign new_slot.arrival = now_ff;
   assign new_slot.left    = req_burst_time;

   always_comb begin
      free_idx = '0;
      for (int i = MAX_WAITING - 1; i >= 0; i--) begin
         valid_vec[i] = slots[i].valid;
         if (!slots[i].valid) begin
            free_idx = IDX_W'(i);
         end
      end
      table_full = &valid_vec;
   end

   always_comb begin
      for (int i = 0; i < MAX_WAITING; i++) begin
         load_en[i]  = queue_it && (free_idx == IDX_W'(i));
         clear_en[i] = (state_ff == ST_DONE) && (best_idx_ff == IDX_W'(i));
      end
   end

   always_comb begin
      if ((head.left == 16'd0) || (best_left_ff == 16'd0)) begin
         beats = (head.left == 16'd0) && ((best_left_ff != 16'd0) || (head_wait > best_wait_ff));
      end else if (prod_a_ff != prod_b_ff) begin
         beats = prod_a_ff > prod_b_ff;
      end else begin
         beats = head_wait > best_wait_ff;
      end
   end

   for (genvar g = 0; g < MAX_WAITING; g++) begin : g_ring
      hrrn_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (state_ff == ST_CMP),
         .shift_in  (slots[(g + 1) % MAX_WAITING]),
         .load_en   (load_en[g]),
         .load_data (new_slot),
         .clear_en  (clear_en[g]),
         .slot_out  (slots[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         run_present_ff <= 1'b0;
         run_id_ff      <= '0;
         run_left_ff    <= '0;
         now_ff         <= '0;
         wcnt_ff        <= '0;
         scan_ff        <= '0;
         have_best_ff   <= 1'b0;
      end else begin
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_type == REQ_ARRIVAL) begin
                     rsp_run_valid_ff <= 1'b1;
                     rsp_dropped_ff   <= run_present_ff && table_full;
                     if (!run_present_ff) begin
                        run_present_ff  <= 1'b1;
                        run_id_ff       <= req_proc_id;
                        run_left_ff     <= req_burst_time;
                        rsp_run_id_ff   <= req_proc_id;
                        rsp_run_left_ff <= req_burst_time;
                        rsp_wcnt_ff     <= 5'(wcnt_ff);
                     end else begin
                        rsp_run_id_ff   <= run_id_ff;
                        rsp_run_left_ff <= run_left_ff;
                        if (!table_full) begin
                           wcnt_ff     <= wcnt_ff + CNT_W'(1);
                           rsp_wcnt_ff <= 5'(wcnt_ff + CNT_W'(1));
                        end else begin
                           rsp_wcnt_ff <= 5'(wcnt_ff);
                        end
                     end
                  end else if (need_sel && (wcnt_ff != '0)) begin
                     state_ff     <= ST_MUL;
                     scan_ff      <= '0;
                     have_best_ff <= 1'b0;
                  end else begin
                     rsp_dropped_ff <= 1'b0;
                     rsp_wcnt_ff    <= 5'(wcnt_ff);
                     now_ff         <= now_ff + 32'd1;
                     if (need_sel) begin
                        run_present_ff   <= 1'b0;
                        run_id_ff        <= '0;
                        run_left_ff      <= '0;
                        rsp_run_valid_ff <= 1'b0;
                        rsp_run_id_ff    <= '0;
                        rsp_run_left_ff  <= '0;
                     end else begin
                        run_left_ff      <= run_left_ff - 16'd1;
                        rsp_run_valid_ff <= 1'b1;
                        rsp_run_id_ff    <= run_id_ff;
                        rsp_run_left_ff  <= run_left_ff - 16'd1;
                     end
                  end
               end
            end
            ST_MUL: begin
               prod_a_ff <= head_wait * best_left_ff;
               prod_b_ff <= best_wait_ff * head.left;
               state_ff  <= ST_CMP;
            end
            ST_CMP: begin
               if (head.valid && (!have_best_ff || beats)) begin
                  have_best_ff <= 1'b1;
                  best_wait_ff <= head_wait;
                  best_left_ff <= head.left;
                  best_id_ff   <= head.id;
                  best_idx_ff  <= scan_ff;
               end
               scan_ff <= scan_ff + IDX_W'(1);
               if (scan_ff == IDX_W'(MAX_WAITING - 1)) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_DONE: begin
               run_present_ff   <= 1'b1;
               run_id_ff        <= best_id_ff;
               run_left_ff      <= best_dec;
               wcnt_ff          <= wcnt_ff - CNT_W'(1);
               now_ff           <= now_ff + 32'd1;
               rsp_run_valid_ff <= 1'b1;
               rsp_run_id_ff    <= best_id_ff;
               rsp_run_left_ff  <= best_dec;
               rsp_dropped_ff   <= 1'b0;
               rsp_wcnt_ff      <= 5'(wcnt_ff - CNT_W'(1));
               state_ff         <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_run_valid     = rsp_run_valid_ff;
   assign rsp_run_id_out    = rsp_run_id_ff;
   assign rsp_run_left_out  = rsp_run_left_ff;
   assign rsp_dropped       = rsp_dropped_ff;
   assign rsp_waiting_count = rsp_wcnt_ff;

endmodule

// File: design/hrrn_checker.sv
`include "assert_macros.svh"

module hrrn_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_run_valid,
   input logic [7:0]  rsp_run_id_out,
   input logic [15:0] rsp_run_left_out,
   input logic        rsp_dropped,
   input logic [4:0]  rsp_waiting_count
);
   import hrrn_pkg::*;

   // stalled result holds its id, time left and waiting count
   `HRRN_ASSERT_IMP(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(rsp_run_id_out) && $stable(rsp_run_left_out) && $stable(rsp_waiting_count)))
   // idle runner reports zeros
   `HRRN_ASSERT_IMP(a_idle_zero, clock, reset, rsp_valid && !rsp_run_valid, (rsp_run_id_out == 8'd0) && (rsp_run_left_out == 16'd0))
   // nothing waits and nothing is dropped while nothing runs
   `HRRN_ASSERT_IMP(a_idle_empty, clock, reset, rsp_valid && !rsp_run_valid, rsp_waiting_count == 5'd0 && !rsp_dropped)
   // drop only on a full table
   `HRRN_ASSERT_IMP(a_drop_full, clock, reset, rsp_valid && rsp_dropped, rsp_waiting_count == 5'(MAX_WAITING))

endmodule

bind hrrn_process_scheduler hrrn_checker u_hrrn_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_run_valid     (rsp_run_valid),
   .rsp_run_id_out    (rsp_run_id_out),
   .rsp_run_left_out  (rsp_run_left_out),
   .rsp_dropped       (rsp_dropped),
   .rsp_waiting_count (rsp_waiting_count)
);
